@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the stable priority ready queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned OccW  = 5;
	localparam int unsigned CmdQDepth = 2;

	typedef enum logic [0:0] {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} spq_cmd_code_t;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} spq_status_t;

	typedef struct packed {
		spq_cmd_code_t     cmd;
		logic [DataW-1:0]  prio;
		logic [DataW-1:0]  tag;
	} spq_cmd_t;

endpackage
`default_nettype wire

@@ design/spq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for queue commands and their results.
// ----------------------------------------------------------------------------
interface spq_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] priority_req;
	logic [7:0] process_id;

	modport source (output valid, output cmd, output priority_req, output process_id,
		input ready);
	modport sink (input valid, input cmd, input priority_req, input process_id,
		output ready);
endinterface

interface spq_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] out_id;
	logic [7:0] out_priority;
	logic [4:0] occupancy;

	modport source (output valid, output status, output out_id, output out_priority,
		output occupancy, input ready);
	modport sink (input valid, input status, input out_id, input out_priority,
		input occupancy, output ready);
endinterface
`default_nettype wire

@@ design/spq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module spq_front
	import spq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_in_if.sink     req,
	output spq_cmd_t   cmd_data,
	output logic       cmd_valid,
	input  wire logic  cmd_ready
);

	localparam int unsigned PtrW = $clog2(CmdQDepth);
	localparam int unsigned CntW = $clog2(CmdQDepth + 1);

	spq_cmd_t          mem_q [CmdQDepth];
	logic [PtrW-1:0]   wptr_q;
	logic [PtrW-1:0]   rptr_q;
	logic [CntW-1:0]   cnt_q;
	logic              push;
	logic              pop;
	spq_cmd_t          in_cmd;

	assign req.ready = (cnt_q != CntW'(CmdQDepth));
	assign cmd_valid = (cnt_q != '0);
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd_data  = mem_q[rptr_q];

	always_comb begin
		in_cmd.cmd  = req.cmd ? CMD_DEQ : CMD_ENQ;
		in_cmd.prio = req.priority_req;
		in_cmd.tag  = req.process_id;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PtrW'(CmdQDepth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PtrW'(CmdQDepth - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/spq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_back
// Sorted shift-register store: inserts an item or removes the head,
// result held in an output register.
// ----------------------------------------------------------------------------
module spq_back
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire spq_cmd_t  cmd_data,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	spq_out_if.source      rsp
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [DataW-1:0]  prio_q [DEPTH];
	logic [DataW-1:0]  tag_q  [DEPTH];
	logic [CntW-1:0]   count_q;
	logic [DEPTH-1:0]  lt;
	logic              fire;
	logic              full;
	logic              empty;
	logic              do_enq;
	logic              do_deq;

	logic              out_valid_q;
	spq_status_t       status_q;
	logic [DataW-1:0]  out_id_q;
	logic [DataW-1:0]  out_prio_q;
	logic [OccW-1:0]   occ_q;

	assign cmd_ready = !out_valid_q || rsp.ready;
	assign fire      = cmd_valid && cmd_ready;
	assign full      = (count_q == CntW'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_enq    = fire && (cmd_data.cmd == CMD_ENQ) && !full;
	assign do_deq    = fire && (cmd_data.cmd == CMD_DEQ) && !empty;

	// slot moves back on insert when empty or of strictly lower priority
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lt[i] = (CntW'(i) >= count_q) || (prio_q[i] < cmd_data.prio);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		always_ff @(posedge clk) begin
			if (do_enq && lt[i]) begin
				if (i == 0) begin
					prio_q[i] <= cmd_data.prio;
					tag_q[i]  <= cmd_data.tag;
				end else begin
					prio_q[i] <= lt[(i > 0) ? i - 1 : 0] ? prio_q[(i > 0) ? i - 1 : 0]
						: cmd_data.prio;
					tag_q[i]  <= lt[(i > 0) ? i - 1 : 0] ? tag_q[(i > 0) ? i - 1 : 0]
						: cmd_data.tag;
				end
			end else if (do_deq && (i < DEPTH - 1)) begin
				prio_q[i] <= prio_q[(i < DEPTH - 1) ? i + 1 : i];
				tag_q[i]  <= tag_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_enq) begin
				count_q <= count_q + 1'b1;
			end else if (do_deq) begin
				count_q <= count_q - 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_id_q   <= '0;
			out_prio_q <= '0;
			if (cmd_data.cmd == CMD_ENQ) begin
				status_q <= full ? ST_FULL : ST_ENQ;
				occ_q    <= full ? OccW'(count_q) : OccW'(count_q + 1'b1);
			end else if (empty) begin
				status_q <= ST_EMPTY;
				occ_q    <= '0;
			end else begin
				status_q   <= ST_DEQ;
				out_id_q   <= tag_q[0];
				out_prio_q <= prio_q[0];
				occ_q      <= OccW'(count_q - 1'b1);
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_id       = out_id_q;
	assign rsp.out_priority = out_prio_q;
	assign rsp.occupancy    = occ_q;

endmodule
`default_nettype wire

@@ design/stable_priority_ready_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_ready_queue
// Bounded ready queue in priority order, FIFO among equal priorities.
// ----------------------------------------------------------------------------
// channel  dir  fields
// req      in   cmd, priority_req, process_id
// rsp      out  status, out_id, out_priority, occupancy
//
// An item passes from req to rsp through the command queue and then the
// sorted store, which inserts an item or removes the head; rsp is registered.
// One item per cycle is sustained while rsp is taken.
// Reset clears the entry count and both queues; no clearing pass.
// A stalled rsp holds its result; req stalls once the command queue is full.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_in_if.sink     req,
	spq_out_if.source  rsp
);

	spq_cmd_t  cmd_data;
	logic      cmd_valid;
	logic      cmd_ready;

	spq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_data  (cmd_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	spq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
